// ===== design/page_frame_alias_table_defines.svh =====
// Assertion macros used by the page frame alias table sequencer (pfat_seq).
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef PAGE_FRAME_ALIAS_TABLE_DEFINES_SVH
`define PAGE_FRAME_ALIAS_TABLE_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define PFAT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define PFAT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFAT_ASSERT(name, prop, msg)
`define PFAT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== design/pfat_pkg.sv =====
// Package for the page frame alias table: sizes, codes and transaction types.
// Used by every module of the block.
package pfat_pkg;

  localparam int FRAMES  = 1024;
  localparam int ALIASES = 2;
  localparam int SLOTS   = FRAMES * ALIASES;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int SUB_W   = (ALIASES > 1) ? $clog2(ALIASES) : 1;
  localparam int IDX_W   = 10;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SUB_W-1:0]  LAST_SUB  = SUB_W'(ALIASES - 1);

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_ALIAS   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FRAME  = 3'd1;
  localparam logic [2:0] ST_REFUSED   = 3'd2;
  localparam logic [2:0] ST_NO_SOURCE = 3'd3;
  localparam logic [2:0] ST_NO_SLOT   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] owner;
    logic [31:0] addr;
    logic [15:0] src_owner;
    logic [31:0] src_addr;
    logic        grant_refused;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] frame_index;
    logic [31:0]      mapped_addr;
  } out_item_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] addr;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic in_ready;
    logic done;
  } seq_stat_t;

endpackage

// ===== design/pfat_slot_ram.sv =====
// Slot store: one write port, one registered read port.
// Depends on pfat_pkg.
module pfat_slot_ram import pfat_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [SLOT_W-1:0] raddr,
  output slot_t             rdata
);

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

// ===== design/pfat_seq.sv =====
// Sequencer: clearing pass, slot scan with one shared compare unit, table updates.
// Depends on pfat_pkg and page_frame_alias_table_defines.svh.
`include "page_frame_alias_table_defines.svh"

module pfat_seq import pfat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_data,
  input  logic              res_pop,
  output seq_stat_t         stat,
  output out_item_t         res,
  output ram_wr_t           wr,
  output logic [SLOT_W-1:0] raddr,
  input  slot_t             rdata
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FILL, S_DONE} state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  out_item_t          res_r, res_nxt;
  logic [SLOT_W-1:0]  iss_addr_r, iss_addr_nxt;
  logic [SUB_W-1:0]   iss_sub_r, iss_sub_nxt;
  logic [FRAME_W-1:0] iss_frame_r, iss_frame_nxt;
  logic               iss_on_r, iss_on_nxt;
  logic               tv_r, tv_nxt;
  logic [SLOT_W-1:0]  t_slot_r, t_slot_nxt;
  logic [SUB_W-1:0]   t_sub_r, t_sub_nxt;
  logic [FRAME_W-1:0] t_frame_r, t_frame_nxt;
  logic               frame_empty_r, frame_empty_nxt;

  logic              issuing;
  logic              get_eff;
  logic              src_hit;
  logic              rel_hit;
  logic [SLOT_W-1:0] base_slot;
  logic [IDX_W-1:0]  t_idx;

  // shared compare unit: works on the slot returned for the tag in flight
  assign src_hit = (rdata.owner == item_r.src_owner) && (item_r.src_owner != '0) &&
                   (rdata.addr == item_r.src_addr);
  assign rel_hit = (rdata.owner == item_r.owner) && (item_r.owner != '0) &&
                   (rdata.addr == item_r.addr);
  assign get_eff = ((t_sub_r == '0) || frame_empty_r) && (rdata.owner == '0);
  assign base_slot = t_slot_r - SLOT_W'(t_sub_r);
  assign t_idx = IDX_W'(t_frame_r);
  assign issuing = ((state_r == S_SCAN) || (state_r == S_FILL)) && iss_on_r;

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    res_nxt         = res_r;
    iss_addr_nxt    = iss_addr_r;
    iss_sub_nxt     = iss_sub_r;
    iss_frame_nxt   = iss_frame_r;
    iss_on_nxt      = iss_on_r;
    tv_nxt          = 1'b0;
    t_slot_nxt      = t_slot_r;
    t_sub_nxt       = t_sub_r;
    t_frame_nxt     = t_frame_r;
    frame_empty_nxt = frame_empty_r;
    wr              = '0;

    if (issuing) begin
      tv_nxt       = 1'b1;
      t_slot_nxt   = iss_addr_r;
      t_sub_nxt    = iss_sub_r;
      t_frame_nxt  = iss_frame_r;
      iss_addr_nxt = iss_addr_r + SLOT_W'(1);
      if (iss_sub_r == LAST_SUB) begin
        iss_sub_nxt   = '0;
        iss_frame_nxt = iss_frame_r + FRAME_W'(1);
      end else begin
        iss_sub_nxt = iss_sub_r + SUB_W'(1);
      end
      if ((state_r == S_SCAN) ? (iss_addr_r == LAST_SLOT) : (iss_sub_r == LAST_SUB)) begin
        iss_on_nxt = 1'b0;
      end
    end

    case (state_r)
      S_CLEAR: begin
        wr.en        = 1'b1;
        wr.addr      = iss_addr_r;
        wr.data      = '0;
        iss_addr_nxt = iss_addr_r + SLOT_W'(1);
        if (iss_addr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.op)
            OP_GET, OP_ALIAS, OP_RELEASE: begin
              state_nxt       = S_SCAN;
              iss_addr_nxt    = '0;
              iss_sub_nxt     = '0;
              iss_frame_nxt   = '0;
              iss_on_nxt      = 1'b1;
              frame_empty_nxt = 1'b1;
            end
            default: begin
              res_nxt   = '{status: ST_NOT_FOUND, frame_index: '0, mapped_addr: '0};
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tv_r) begin
          case (item_r.op)
            OP_GET: begin
              if ((t_sub_r == LAST_SUB) && get_eff) begin
                wr.en   = 1'b1;
                wr.addr = base_slot;
                if (item_r.grant_refused) begin
                  wr.data = '0;
                  res_nxt = '{status: ST_REFUSED, frame_index: '0, mapped_addr: '0};
                end else begin
                  wr.data = '{owner: item_r.owner, addr: item_r.addr};
                  res_nxt = '{status: ST_OK, frame_index: t_idx, mapped_addr: item_r.addr};
                end
                state_nxt  = S_DONE;
                iss_on_nxt = 1'b0;
                tv_nxt     = 1'b0;
              end else if (t_slot_r == LAST_SLOT) begin
                res_nxt    = '{status: ST_NO_FRAME, frame_index: '0, mapped_addr: '0};
                state_nxt  = S_DONE;
                iss_on_nxt = 1'b0;
                tv_nxt     = 1'b0;
              end else begin
                frame_empty_nxt = get_eff;
              end
            end
            OP_ALIAS: begin
              if (src_hit) begin
                // rescan the source frame for its first empty slot
                state_nxt     = S_FILL;
                iss_addr_nxt  = base_slot;
                iss_sub_nxt   = '0;
                iss_frame_nxt = t_frame_r;
                iss_on_nxt    = 1'b1;
                tv_nxt        = 1'b0;
              end else if (t_slot_r == LAST_SLOT) begin
                res_nxt    = '{status: ST_NO_SOURCE, frame_index: '0, mapped_addr: '0};
                state_nxt  = S_DONE;
                iss_on_nxt = 1'b0;
                tv_nxt     = 1'b0;
              end
            end
            OP_RELEASE: begin
              if (rel_hit) begin
                wr.en      = 1'b1;
                wr.addr    = t_slot_r;
                wr.data    = '0;
                res_nxt    = '{status: ST_OK, frame_index: t_idx, mapped_addr: '0};
                state_nxt  = S_DONE;
                iss_on_nxt = 1'b0;
                tv_nxt     = 1'b0;
              end else if (t_slot_r == LAST_SLOT) begin
                res_nxt    = '{status: ST_NOT_FOUND, frame_index: '0, mapped_addr: '0};
                state_nxt  = S_DONE;
                iss_on_nxt = 1'b0;
                tv_nxt     = 1'b0;
              end
            end
            default: begin
              res_nxt    = '{status: ST_NOT_FOUND, frame_index: '0, mapped_addr: '0};
              state_nxt  = S_DONE;
              iss_on_nxt = 1'b0;
              tv_nxt     = 1'b0;
            end
          endcase
        end
      end
      S_FILL: begin
        if (tv_r) begin
          if (rdata.owner == '0) begin
            if (item_r.grant_refused) begin
              res_nxt = '{status: ST_REFUSED, frame_index: '0, mapped_addr: '0};
            end else begin
              wr.en   = 1'b1;
              wr.addr = t_slot_r;
              wr.data = '{owner: item_r.owner, addr: item_r.addr};
              res_nxt = '{status: ST_OK, frame_index: t_idx, mapped_addr: item_r.addr};
            end
            state_nxt  = S_DONE;
            iss_on_nxt = 1'b0;
            tv_nxt     = 1'b0;
          end else if (t_sub_r == LAST_SUB) begin
            res_nxt    = '{status: ST_NO_SLOT, frame_index: '0, mapped_addr: '0};
            state_nxt  = S_DONE;
            iss_on_nxt = 1'b0;
            tv_nxt     = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (res_pop) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      iss_addr_r <= '0;
      iss_on_r   <= 1'b0;
      tv_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_addr_r <= iss_addr_nxt;
      iss_on_r   <= iss_on_nxt;
      tv_r       <= tv_nxt;
    end
    item_r        <= item_nxt;
    res_r         <= res_nxt;
    iss_sub_r     <= iss_sub_nxt;
    iss_frame_r   <= iss_frame_nxt;
    t_slot_r      <= t_slot_nxt;
    t_sub_r       <= t_sub_nxt;
    t_frame_r     <= t_frame_nxt;
    frame_empty_r <= frame_empty_nxt;
  end

  assign raddr         = iss_addr_r;
  assign res           = res_r;
  assign stat.in_ready = (state_r == S_IDLE);
  assign stat.done     = (state_r == S_DONE);

  `PFAT_ASSERT(a_wr_when_busy, wr.en |-> (state_r == S_CLEAR || state_r == S_SCAN || state_r == S_FILL), "table write outside clear or scan")
  `PFAT_ASSERT(a_tag_in_scan, tv_r |-> (state_r == S_SCAN || state_r == S_FILL), "slot tag live outside a scan")
  `PFAT_ASSERT(a_done_holds, (state_r == S_DONE && !res_pop) |=> (state_r == S_DONE && $stable(res_r)), "result dropped before it was taken")
  `PFAT_ASSERT(a_get_addr, (state_r == S_DONE && item_r.op == OP_GET && res_r.status == ST_OK) |-> (res_r.mapped_addr == item_r.addr), "get result address mismatch")
  `PFAT_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (state_r == S_CLEAR && !tv_r), "reset did not start the clearing pass")

endmodule

// ===== design/page_frame_alias_table.sv =====
// Page frame alias table: frames of alias slots scanned one slot per cycle.
// Worst case per transaction: a full scan of the slot RAM through its read port,
// plus a rescan of one frame for alias.
// One transaction at a time: the sequencer returns to idle and raises in_ready as the result
// enters the output register, which waits while out_ready holds off the previous result.
// Reset: synchronous, active low; then a clearing pass over all FRAMES*ALIASES slots (2048)
// zeroes the slot RAM, with in_ready low throughout.
module page_frame_alias_table import pfat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  seq_stat_t         stat;
  out_item_t         res;
  ram_wr_t           wr;
  logic [SLOT_W-1:0] raddr;
  slot_t             rdata;
  logic              pop;
  logic              out_valid_r;
  out_item_t         out_data_r;

  pfat_slot_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  pfat_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .res_pop  (pop),
    .stat     (stat),
    .res      (res),
    .wr       (wr),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  // result register: the sequencer may finish once it is free or being drained
  assign pop = stat.done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      out_data_r <= res;
    end
  end

  assign in_ready  = stat.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/page_frame_alias_table_tb.sv =====
// Testbench for page_frame_alias_table: directed rows, then random traffic under
// several idle and stall patterns, checked against a shadow copy of the frame table.
// Depends on pfat_pkg and the page_frame_alias_table RTL.
`timescale 1ns / 100ps

module page_frame_alias_table_tb;
  import pfat_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int RAND_PER_PH  = 62;
  localparam int HOLD_ITEMS   = 8;
  localparam int HOLD_CYCLES  = 6000;    // longer than two full scans
  localparam int TAIL_ITEMS   = 20;
  localparam int SETTLE_WAIT  = 2100;    // a bit over the worst scan latency
  localparam int CYCLE_LIMIT  = 12000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // shadow of the frame table
  logic [15:0] shadow_owner [SLOTS];
  logic [31:0] shadow_vaddr [SLOTS];

  out_item_t pending_answers[$];
  row_t      rows[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;
  bit        hold_armed = 1'b0;
  bit        hold_used = 1'b0;
  int        hold_left = 0;

  page_frame_alias_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d transactions still expected", $time, pending_answers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int first_empty_frame();
    int f, s;
    bit empty;
    for (f = 0; f < FRAMES; f++) begin
      empty = 1'b1;
      for (s = 0; s < ALIASES; s++)
        if (shadow_owner[f * ALIASES + s] != '0) empty = 1'b0;
      if (empty) return f;
    end
    return -1;
  endfunction

  // empty slots never match, so owner 0 finds nothing
  function automatic int find_mapping(input logic [15:0] who, input logic [31:0] where);
    int i;
    if (who == '0) return -1;
    for (i = 0; i < SLOTS; i++)
      if (shadow_owner[i] == who && shadow_vaddr[i] == where) return i;
    return -1;
  endfunction

  function automatic out_item_t table_answer(input in_item_t it);
    out_item_t res;
    int fr, sl, base, s;
    bit placed;
    res = '0;
    res.status = ST_NOT_FOUND;
    case (it.op)
      OP_GET: begin
        fr = first_empty_frame();
        if (fr < 0) begin
          res.status = ST_NO_FRAME;
        end else if (it.grant_refused) begin
          shadow_owner[fr * ALIASES] = '0;
          shadow_vaddr[fr * ALIASES] = '0;
          res.status = ST_REFUSED;
        end else begin
          shadow_owner[fr * ALIASES] = it.owner;
          shadow_vaddr[fr * ALIASES] = it.addr;
          res.status = ST_OK;
          res.frame_index = IDX_W'(fr);
          res.mapped_addr = it.addr;
        end
      end
      OP_ALIAS: begin
        sl = find_mapping(it.src_owner, it.src_addr);
        if (sl < 0) begin
          res.status = ST_NO_SOURCE;
        end else begin
          base = (sl / ALIASES) * ALIASES;
          res.status = ST_NO_SLOT;
          placed = 1'b0;
          for (s = 0; s < ALIASES; s++) begin
            if (!placed && shadow_owner[base + s] == '0) begin
              placed = 1'b1;
              if (it.grant_refused) begin
                res.status = ST_REFUSED;
              end else begin
                shadow_owner[base + s] = it.owner;
                shadow_vaddr[base + s] = it.addr;
                res.status = ST_OK;
                res.frame_index = IDX_W'(sl / ALIASES);
                res.mapped_addr = it.addr;
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        sl = find_mapping(it.owner, it.addr);
        if (sl >= 0) begin
          shadow_owner[sl] = '0;
          shadow_vaddr[sl] = '0;
          res.status = ST_OK;
          res.frame_index = IDX_W'(sl / ALIASES);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t req(input logic [1:0] op, input logic [15:0] owner,
                                   input logic [31:0] addr, input logic [15:0] src_owner,
                                   input logic [31:0] src_addr, input logic refused);
    in_item_t it;
    it.op = op;
    it.owner = owner;
    it.addr = addr;
    it.src_owner = src_owner;
    it.src_addr = src_addr;
    it.grant_refused = refused;
    return it;
  endfunction

  function automatic out_item_t ans(input logic [2:0] status, input int frame,
                                    input logic [31:0] mapped);
    out_item_t o;
    o.status = status;
    o.frame_index = IDX_W'(frame);
    o.mapped_addr = mapped;
    return o;
  endfunction

  function automatic void add_row(input in_item_t it, input logic typed, input out_item_t want);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  // small pools make duplicate mappings and hits likely
  function automatic logic [15:0] rand_owner();
    case ($urandom_range(19))
      0:             return '0;
      1, 2, 3, 4, 5: return 16'($urandom_range(4, 1));
      default:       return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_vaddr();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_1000;
      2:       return 32'hFFFF_F000;
      default: return $urandom();
    endcase
  endfunction

  function automatic int live_slot();
    int start, i, idx;
    start = $urandom_range(SLOTS - 1);
    for (i = 0; i < SLOTS; i++) begin
      idx = (start + i) % SLOTS;
      if (shadow_owner[idx] != '0) return idx;
    end
    return -1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick, sl;
    it = req(OP_GET, rand_owner(), rand_vaddr(), rand_owner(), rand_vaddr(),
             $urandom_range(99) < 15);
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.op = OP_GET;
    end else if (pick < 65) begin
      it.op = OP_ALIAS;
      sl = live_slot();
      if (sl >= 0 && $urandom_range(99) < 85) begin
        it.src_owner = shadow_owner[sl];
        it.src_addr = shadow_vaddr[sl];
      end
    end else if (pick < 95) begin
      it.op = OP_RELEASE;
      sl = live_slot();
      if (sl >= 0 && $urandom_range(99) < 80) begin
        it.owner = shadow_owner[sl];
        it.addr = shadow_vaddr[sl];
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // prediction happens at the accepting edge, in transaction order
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = table_answer(it);
    pending_answers.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_answers.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected transaction status=%0d frame=%0d addr=%h",
               $time, got.status, got.frame_index, got.mapped_addr);
    end else begin
      want = pending_answers.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.frame_index !== want.frame_index) begin
        mismatches++;
        $display("%0t: frame_index expected %0d actual %0d",
                 $time, want.frame_index, got.frame_index);
      end
      if (got.mapped_addr !== want.mapped_addr) begin
        mismatches++;
        $display("%0t: mapped_addr expected %h actual %h",
                 $time, want.mapped_addr, got.mapped_addr);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (hold_armed && !hold_used) begin
      hold_left = HOLD_CYCLES;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    int i, ph, k;
    add_row(req(OP_RELEASE, 16'd1, 32'h0, '0, '0, 1'b0), 1'b1, ans(ST_NOT_FOUND, 0, '0));
    add_row(req(OP_ALIAS, 16'd2, 32'h0, 16'd1, 32'h0, 1'b0), 1'b1, ans(ST_NO_SOURCE, 0, '0));
    add_row(req(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, 1'b1), 1'b1, ans(ST_REFUSED, 0, '0));
    add_row(req(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, 1'b0), 1'b1,
            ans(ST_OK, 0, 32'hFFFF_FFFF));
    add_row(req(OP_GET, 16'd1, 32'h0, '0, '0, 1'b0), 1'b1, ans(ST_OK, 1, '0));
    add_row(req(OP_ALIAS, 16'd2, 32'h1234_5678, 16'hFFFF, 32'hFFFF_FFFF, 1'b1), 1'b1,
            ans(ST_REFUSED, 0, '0));
    add_row(req(OP_ALIAS, 16'd2, 32'h1234_5678, 16'hFFFF, 32'hFFFF_FFFF, 1'b0), 1'b1,
            ans(ST_OK, 0, 32'h1234_5678));
    // frame full: grant bit is not looked at
    add_row(req(OP_ALIAS, 16'd3, 32'h5, 16'd2, 32'h1234_5678, 1'b1), 1'b1,
            ans(ST_NO_SLOT, 0, '0));
    add_row(req(OP_ALIAS, 16'd3, 32'h5, '0, '0, 1'b0), 1'b1, ans(ST_NO_SOURCE, 0, '0));
    add_row(req(OP_RELEASE, '0, '0, '0, '0, 1'b0), 1'b1, ans(ST_NOT_FOUND, 0, '0));
    // owner 0 leaves the frame empty, so the next get lands on it again
    add_row(req(OP_GET, '0, 32'hDEAD_BEEF, '0, '0, 1'b0), 1'b1, ans(ST_OK, 2, 32'hDEAD_BEEF));
    add_row(req(OP_GET, 16'd7, 32'hA5A5_A5A5, '0, '0, 1'b0), 1'b1,
            ans(ST_OK, 2, 32'hA5A5_A5A5));
    add_row(req(OP_UNUSED, 16'd7, 32'hA5A5_A5A5, 16'd7, 32'hA5A5_A5A5, 1'b0), 1'b1,
            ans(ST_NOT_FOUND, 0, '0));
    add_row(req(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, 1'b1), 1'b1, ans(ST_OK, 0, '0));
    add_row(req(OP_ALIAS, 16'd4, 32'h0, 16'd2, 32'h1234_5678, 1'b0), 1'b1, ans(ST_OK, 0, '0));
    add_row(req(OP_RELEASE, 16'd2, 32'h1234_5678, '0, '0, 1'b0), 1'b1, ans(ST_OK, 0, '0));
    add_row(req(OP_RELEASE, 16'd2, 32'h1234_5678, '0, '0, 1'b0), 1'b1,
            ans(ST_NOT_FOUND, 0, '0));
    add_row(req(OP_ALIAS, '0, 32'h5555_5555, 16'd4, 32'h0, 1'b0), 1'b1,
            ans(ST_OK, 0, 32'h5555_5555));
    add_row(req(OP_RELEASE, 16'd1, 32'h0, '0, '0, 1'b0), 1'b1, ans(ST_OK, 1, '0));
    add_row(req(OP_GET, 16'hAAAA, 32'h0, '0, '0, 1'b0), 1'b0, '0);
    add_row(req(OP_ALIAS, 16'h5555, 32'hAAAA_AAAA, 16'd7, 32'hA5A5_A5A5, 1'b0), 1'b0, '0);
    add_row(req(OP_GET, 16'h8000, 32'h8000_0000, '0, '0, 1'b0), 1'b0, '0);
    add_row(req(OP_ALIAS, 16'h1234, 32'h1, 16'hAAAA, 32'h0, 1'b1), 1'b1,
            ans(ST_REFUSED, 0, '0));

    for (i = 0; i < SLOTS; i++) begin
      shadow_owner[i] = '0;
      shadow_vaddr[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) send_item(rows[r].item, rows[r].typed, rows[r].want);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 83; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 83; end
        default: begin snd_idle_pct = 33; rcv_stall_pct = 33; end
      endcase
      for (k = 0; k < RAND_PER_PH; k++) send_item(random_item(), 1'b0, '0);
      drain();
    end

    // receiver holds off while transactions keep coming, so in_ready backs up
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_armed = 1'b1;
    for (k = 0; k < HOLD_ITEMS; k++) send_item(random_item(), 1'b0, '0);
    drain();

    for (k = 0; k < TAIL_ITEMS; k++) send_item(random_item(), 1'b0, '0);
    drain();

    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
